// File: rtl/mbg_pkg.sv
// Shared types and codes for the maze backtracker generator.
`timescale 1ns / 1ps
package mbg_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_CARVE = 2'd1;
    localparam logic [1:0] EV_BACK  = 2'd2;
    localparam logic [1:0] EV_IDLE  = 2'd3;

    localparam logic REG_FIELD_WIDTH  = 1'b0;
    localparam logic REG_FIELD_HEIGHT = 1'b1;

    localparam logic [6:0] FIELD_DOTS_RESET = 7'd64;

    // floor(x * RECIP3 / 2^16) == floor(x / 3) for every 15-bit x
    localparam logic [14:0] RECIP3       = 15'd21846;
    localparam int          RECIP3_SHIFT = 16;

    typedef enum logic [1:0] {
        DIR_XP = 2'd0,
        DIR_XM = 2'd1,
        DIR_YP = 2'd2,
        DIR_YM = 2'd3
    } dir_t;

    typedef struct packed {
        logic found;
        dir_t dir;
    } pick_t;

endpackage

// File: rtl/maze_backtracker_generator_unit.sv
// Top level: randomized depth-first maze carver with visited map and path stack memories.
`timescale 1ns / 1ps
// Each input transfer yields one result transfer. For a step, the visited
// map has two read ports, so the four neighbor bits are read in two rounds
// (at acceptance and in RD1), then EVAL decides and writes back (visited bit,
// stack push or pop) and FIN loads the output register. A step on a finished
// maze goes straight to FIN. A start sweeps the whole visited map clear, one
// entry per cycle over 2^(clog2(MAX_FIELD_WIDTH/2) + clog2(MAX_FIELD_HEIGHT/2))
// entries (1024 at the defaults), then goes through MARK and FIN. Grid size
// registers are sampled at a start only.
module maze_backtracker_generator_unit
    import mbg_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH  = 64,
    parameter int MAX_FIELD_HEIGHT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,    // operation
    input  logic [31:0] s_tdata,    // rand_value, start_x, start_y, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,    // event_res
    output logic [39:0] m_tdata     // wall_x, wall_y, pos_x, pos_y, cells_left,
                                    // maze_done, zero pad
);

    localparam int CELLS_X   = MAX_FIELD_WIDTH / 2;
    localparam int CELLS_Y   = MAX_FIELD_HEIGHT / 2;
    localparam int CXW       = $clog2(CELLS_X);
    localparam int CYW       = $clog2(CELLS_Y);
    localparam int AW        = CXW + CYW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int COLW      = CXW + 1;
    localparam int ROWW      = CYW + 1;
    localparam int CNTW      = AW + 1;
    localparam int DOTW      = 9;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLEAR = 6'b000010,
        ST_MARK  = 6'b000100,
        ST_RD1   = 6'b001000,
        ST_EVAL  = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [6:0]      field_width_reg, field_height_reg;
    logic [COLW-1:0] cols_reg, cols_next;
    logic [ROWW-1:0] rows_reg, rows_next;
    logic [CXW-1:0]  cur_x_reg, cur_x_next;
    logic [CYW-1:0]  cur_y_reg, cur_y_next;
    logic [AW:0]     depth_reg, depth_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            running_reg, running_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [1:0]      rnd_reg, rnd_next;
    logic [1:0]      rem3_reg, rem3_next;
    logic            vis_xp_reg, vis_xm_reg;
    logic [1:0]      res_event_reg, res_event_next;
    logic [5:0]      res_wall_x_reg, res_wall_x_next;
    logic [5:0]      res_wall_y_reg, res_wall_y_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [1:0]      m_tuser_reg, m_tuser_next;
    logic [39:0]     m_tdata_reg, m_tdata_next;

    logic            vis_mem [MEM_DEPTH];
    logic            vis_we, vis_wdata, vis_re;
    logic [AW-1:0]   vis_waddr, vis_ra0, vis_ra1;
    logic            vis_q0, vis_q1;

    logic [AW-1:0]   stk_mem [MEM_DEPTH];
    logic            stk_we, stk_re;
    logic [AW-1:0]   stk_q;
    logic [AW:0]     depth_dec;

    logic            accept;
    logic [14:0]     in_rand;
    logic [5:0]      in_start_x, in_start_y;
    logic [29:0]     rnd_prod;
    logic [16:0]     rnd_rem;

    logic [DOTW-1:0] w_eff, h_eff;
    logic [COLW-1:0] cols_new;
    logic [ROWW-1:0] rows_new;
    logic [AW+1:0]   area_new;
    logic [CXW-1:0]  start_cx;
    logic [CYW-1:0]  start_cy;

    logic [AW-1:0]   addr_cur, addr_xp, addr_xm, addr_yp, addr_ym, addr_new;
    logic            xp_ok, xm_ok, yp_ok, ym_ok;
    logic [3:0]      avail;
    pick_t           pick;
    logic [CXW+1:0]  dot_x;
    logic [CYW+1:0]  dot_y;
    logic [CXW-1:0]  new_x;
    logic [CYW-1:0]  new_y;
    logic [5:0]      wall_x, wall_y;
    logic            maze_done;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_rand    = s_tdata[14:0];
    assign in_start_x = s_tdata[20:15];
    assign in_start_y = s_tdata[26:21];

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // rand modulo 3 by reciprocal
    assign rnd_prod = 30'(in_rand) * 30'(RECIP3);
    assign rnd_rem  = 17'(in_rand) - {2'b00, rnd_prod[29:RECIP3_SHIFT], 1'b0}
                    - 17'(rnd_prod[29:RECIP3_SHIFT]);

    // grid geometry for a start
    always_comb
    begin
        w_eff = (DOTW'(field_width_reg) > DOTW'(MAX_FIELD_WIDTH)) ?
                DOTW'(MAX_FIELD_WIDTH) : DOTW'(field_width_reg);
        h_eff = (DOTW'(field_height_reg) > DOTW'(MAX_FIELD_HEIGHT)) ?
                DOTW'(MAX_FIELD_HEIGHT) : DOTW'(field_height_reg);
        cols_new = (w_eff == '0) ? '0 : COLW'((w_eff - 1'b1) >> 1);
        rows_new = (h_eff == '0) ? '0 : ROWW'((h_eff - 1'b1) >> 1);
        area_new = (AW+2)'(cols_new) * (AW+2)'(rows_new);
        if (cols_new == '0)
        begin
            start_cx = '0;
        end
        else if (8'(in_start_x[5:1]) >= 8'(cols_new))
        begin
            start_cx = CXW'(cols_new - 1'b1);
        end
        else
        begin
            start_cx = CXW'(in_start_x[5:1]);
        end
        if (rows_new == '0)
        begin
            start_cy = '0;
        end
        else if (8'(in_start_y[5:1]) >= 8'(rows_new))
        begin
            start_cy = CYW'(rows_new - 1'b1);
        end
        else
        begin
            start_cy = CYW'(in_start_y[5:1]);
        end
    end

    // neighbors of the current cell
    assign addr_cur = {cur_y_reg, cur_x_reg};
    assign addr_xp  = {cur_y_reg, cur_x_reg + 1'b1};
    assign addr_xm  = {cur_y_reg, cur_x_reg - 1'b1};
    assign addr_yp  = {cur_y_reg + 1'b1, cur_x_reg};
    assign addr_ym  = {cur_y_reg - 1'b1, cur_x_reg};
    assign xp_ok    = (COLW'(cur_x_reg) + 1'b1) < cols_reg;
    assign xm_ok    = (cur_x_reg != '0);
    assign yp_ok    = (ROWW'(cur_y_reg) + 1'b1) < rows_reg;
    assign ym_ok    = (cur_y_reg != '0);
    assign avail    = {ym_ok && !vis_q1, yp_ok && !vis_q0,
                       xm_ok && !vis_xm_reg, xp_ok && !vis_xp_reg};

    mbg_pick u_pick (
        .avail   (avail),
        .rnd_low (rnd_reg),
        .rem3    (rem3_reg),
        .pick    (pick)
    );

    assign dot_x = {1'b0, cur_x_reg, 1'b1};
    assign dot_y = {1'b0, cur_y_reg, 1'b1};

    always_comb
    begin
        new_x  = cur_x_reg;
        new_y  = cur_y_reg;
        wall_x = 6'(dot_x);
        wall_y = 6'(dot_y);
        unique case (pick.dir)
            DIR_XP:
            begin
                new_x  = cur_x_reg + 1'b1;
                wall_x = 6'(dot_x + 1'b1);
            end
            DIR_XM:
            begin
                new_x  = cur_x_reg - 1'b1;
                wall_x = 6'(dot_x - 1'b1);
            end
            DIR_YP:
            begin
                new_y  = cur_y_reg + 1'b1;
                wall_y = 6'(dot_y + 1'b1);
            end
            DIR_YM:
            begin
                new_y  = cur_y_reg - 1'b1;
                wall_y = 6'(dot_y - 1'b1);
            end
        endcase
    end

    assign addr_new  = {new_y, new_x};
    assign depth_dec = depth_reg - 1'b1;
    assign maze_done = !running_reg && (cnt_reg == '0);

    // memory port control
    always_comb
    begin
        vis_re    = 1'b0;
        vis_ra0   = addr_xp;
        vis_ra1   = addr_xm;
        vis_we    = 1'b0;
        vis_waddr = addr_new;
        vis_wdata = 1'b1;
        stk_re    = accept && (s_tuser == OP_STEP) && running_reg;
        stk_we    = 1'b0;
        priority case (1'b1)
            state_reg[0]:
            begin
                vis_re = stk_re;
            end
            state_reg[1]:
            begin
                vis_we    = 1'b1;
                vis_waddr = clr_addr_reg;
                vis_wdata = 1'b0;
            end
            state_reg[2]:
            begin
                vis_we    = (cols_reg != '0) && (rows_reg != '0);
                vis_waddr = addr_cur;
            end
            state_reg[3]:
            begin
                vis_re  = 1'b1;
                vis_ra0 = addr_yp;
                vis_ra1 = addr_ym;
            end
            state_reg[4]:
            begin
                vis_we = pick.found;
                stk_we = pick.found && !depth_reg[AW];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        if (vis_re)
        begin
            vis_q0 <= vis_mem[vis_ra0];
            vis_q1 <= vis_mem[vis_ra1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[depth_reg[AW-1:0]] <= addr_cur;
        end
        if (stk_re)
        begin
            stk_q <= stk_mem[depth_dec[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD1)
        begin
            vis_xp_reg <= vis_q0;
            vis_xm_reg <= vis_q1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cols_next       = cols_reg;
        rows_next       = rows_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        depth_next      = depth_reg;
        cnt_next        = cnt_reg;
        running_next    = running_reg;
        clr_addr_next   = clr_addr_reg;
        rnd_next        = rnd_reg;
        rem3_next       = rem3_reg;
        res_event_next  = res_event_reg;
        res_wall_x_next = res_wall_x_reg;
        res_wall_y_next = res_wall_y_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rnd_next        = in_rand[1:0];
                    rem3_next       = rnd_rem[1:0];
                    res_wall_x_next = '0;
                    res_wall_y_next = '0;
                    if (s_tuser == OP_START)
                    begin
                        cols_next      = cols_new;
                        rows_next      = rows_new;
                        depth_next     = '0;
                        clr_addr_next  = '0;
                        res_event_next = EV_START;
                        if ((cols_new == '0) || (rows_new == '0))
                        begin
                            cur_x_next   = '0;
                            cur_y_next   = '0;
                            cnt_next     = '0;
                            running_next = 1'b0;
                        end
                        else
                        begin
                            cur_x_next   = start_cx;
                            cur_y_next   = start_cy;
                            cnt_next     = CNTW'(area_new - 1'b1);
                            running_next = (area_new != (AW+2)'(1));
                        end
                        state_next = ST_CLEAR;
                    end
                    else if (running_reg)
                    begin
                        state_next = ST_RD1;
                    end
                    else
                    begin
                        res_event_next = EV_IDLE;
                        state_next     = ST_FIN;
                    end
                end
            end
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                state_next = ST_FIN;
            end
            ST_RD1:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = ST_FIN;
                if (pick.found)
                begin
                    if (!depth_reg[AW])
                    begin
                        depth_next = depth_reg + 1'b1;
                    end
                    cur_x_next      = new_x;
                    cur_y_next      = new_y;
                    cnt_next        = cnt_reg - CNTW'(cnt_reg != '0);
                    running_next    = (cnt_next != '0);
                    res_event_next  = EV_CARVE;
                    res_wall_x_next = wall_x;
                    res_wall_y_next = wall_y;
                end
                else if (depth_reg != '0)
                begin
                    depth_next     = depth_dec;
                    cur_x_next     = stk_q[CXW-1:0];
                    cur_y_next     = stk_q[AW-1:CXW];
                    res_event_next = EV_BACK;
                end
                else
                begin
                    running_next   = 1'b0;
                    res_event_next = EV_IDLE;
                end
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_event_reg;
                    m_tdata_next  = {4'b0000, maze_done, 11'(cnt_reg),
                                     6'(dot_y), 6'(dot_x),
                                     res_wall_y_reg, res_wall_x_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            field_width_reg  <= FIELD_DOTS_RESET;
            field_height_reg <= FIELD_DOTS_RESET;
            cols_reg         <= '0;
            rows_reg         <= '0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            depth_reg        <= '0;
            cnt_reg          <= '0;
            running_reg      <= 1'b0;
            clr_addr_reg     <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            depth_reg    <= depth_next;
            cnt_reg      <= cnt_next;
            running_reg  <= running_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we && (cfg_addr == REG_FIELD_WIDTH))
            begin
                field_width_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_addr == REG_FIELD_HEIGHT))
            begin
                field_height_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg        <= rnd_next;
        rem3_reg       <= rem3_next;
        res_event_reg  <= res_event_next;
        res_wall_x_reg <= res_wall_x_next;
        res_wall_y_reg <= res_wall_y_next;
        m_tuser_reg    <= m_tuser_next;
        m_tdata_reg    <= m_tdata_next;
    end

`ifndef SYNTH
    a_running_has_cells: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (cnt_reg != '0))
        else $error("running with no unvisited cells");

    a_carve_wall_parity: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == EV_CARVE)) |-> (m_tdata[0] != m_tdata[6]))
        else $error("carved wall not between two cells");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after an accepted transfer");
`endif

endmodule

// File: rtl/mbg_pick.sv
// Neighbor choice: random index modulo the count of open neighbors.
`timescale 1ns / 1ps
module mbg_pick
    import mbg_pkg::*;
(
    input  logic [3:0] avail,     // +x, -x, +y, -y
    input  logic [1:0] rnd_low,   // random word, low two bits
    input  logic [1:0] rem3,      // random word modulo 3
    output pick_t      pick
);

    always_comb
    begin
        logic [2:0] n;
        logic [2:0] sel;
        logic [2:0] seen;
        dir_t       dir;
        n    = 3'(avail[0]) + 3'(avail[1]) + 3'(avail[2]) + 3'(avail[3]);
        seen = 3'd0;
        dir  = DIR_XP;
        unique case (n)
            3'd2:    sel = {2'b00, rnd_low[0]};
            3'd3:    sel = {1'b0, rem3};
            3'd4:    sel = {1'b0, rnd_low};
            default: sel = 3'd0;
        endcase
        for (int i = 0; i < 4; i++)
        begin
            if (avail[i])
            begin
                if (seen == sel)
                begin
                    dir = dir_t'(2'(i));
                end
                seen = seen + 3'd1;
            end
        end
        pick.found = |avail;
        pick.dir   = dir;
    end

endmodule
